// ===== hdl/pru_pkg.sv =====
// shared types and constants of the pixel replicate upscaler
`timescale 1ns / 1ps

package pru_pkg;

    // field widths
    localparam int unsigned SCALE_W = 7;
    localparam int unsigned WIDTH_W = 11;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned RGB_W   = 3 * COLOR_W;

    // largest enlargement factor
    localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd100;

    // input item kinds
    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_TICK  = 1'b1
    } in_kind_t;

    // output item kinds
    typedef enum logic [1:0] {
        ITEM_PIXEL  = 2'd0,
        ITEM_PAD    = 2'd1,
        ITEM_REFUSE = 2'd2
    } item_kind_t;

    // configuration register indexes
    typedef enum logic {
        REG_SCALE = 1'b0,
        REG_WIDTH = 1'b1
    } reg_index_t;

    // control part of an item in flight
    typedef struct packed {
        item_kind_t item_kind;
        logic       row_end;
        logic       block_end;
    } out_meta_t;

endpackage

// ===== hdl/pru_if.sv =====
// stream and configuration interfaces of the pixel replicate upscaler
`timescale 1ns / 1ps

interface pru_in_if;
    logic                              valid;
    logic                              ready;
    pru_pkg::in_kind_t                 kind;
    logic [pru_pkg::COLOR_W-1:0]       red_in;
    logic [pru_pkg::COLOR_W-1:0]       green_in;
    logic [pru_pkg::COLOR_W-1:0]       blue_in;

    modport source (output valid, kind, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface pru_out_if;
    logic                              valid;
    logic                              ready;
    pru_pkg::item_kind_t               item_kind;
    logic [pru_pkg::COLOR_W-1:0]       red_out;
    logic [pru_pkg::COLOR_W-1:0]       green_out;
    logic [pru_pkg::COLOR_W-1:0]       blue_out;
    logic                              row_end;
    logic                              block_end;

    modport source (output valid, item_kind, red_out, green_out, blue_out, row_end,
                    block_end, input ready);
    modport sink   (input valid, item_kind, red_out, green_out, blue_out, row_end,
                    block_end, output ready);
endinterface

interface pru_cfg_if;
    logic                              valid;
    logic                              ready;
    pru_pkg::reg_index_t               index;
    logic [pru_pkg::WIDTH_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/pru_ram.sv =====
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module pru_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/pixel_replicate_upscaler.sv =====
// pixel replicate upscaler top level: line store fill and scaled drain
// path: a tick's result passes the s1 register and then the result register before it is offered
// throughput: one item per cycle, pixels and ticks alike, set by the two-register
//   output pipeline that takes a new item whenever its result register frees up
// reset: counters clear and the block starts filling, scale and width read 1;
//   line store contents are undefined until written, no clearing pass
`timescale 1ns / 1ps

module pixel_replicate_upscaler #(
    parameter int unsigned MAX_LINE_WIDTH = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    pru_in_if.sink    pix_in,
    pru_out_if.source pix_out,
    pru_cfg_if.sink   cfg
);

    localparam int unsigned AW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int unsigned SW = pru_pkg::SCALE_W;
    localparam int unsigned WW = pru_pkg::WIDTH_W;
    localparam int unsigned CW = pru_pkg::COLOR_W;
    localparam int unsigned RW = pru_pkg::RGB_W;

    // configuration registers
    logic [SW-1:0] scale_reg;
    logic [WW-1:0] width_reg;

    // drain / fill control state
    logic [WW-1:0] fill_reg,  fill_next;
    logic          drain_reg, drain_next;
    logic [SW-1:0] row_reg,   row_next;
    logic [WW-1:0] col_reg,   col_next;
    logic [SW-1:0] rep_reg,   rep_next;
    logic [1:0]    pad_reg,   pad_next;

    // pipeline: s1 waits on the ram read, out is the result register
    logic               s1_valid_reg, s1_valid_next;
    pru_pkg::out_meta_t s1_meta_reg,  s1_meta_next;
    logic               out_valid_reg;
    pru_pkg::out_meta_t out_meta_reg;
    logic [RW-1:0]      out_rgb_reg;

    // effective settings
    logic [SW-1:0] scale_eff;
    logic [WW-1:0] width_eff;
    logic [1:0]    low_bytes;
    logic [1:0]    pad_eff;

    logic          accept;
    logic          s1_adv;
    logic          has_result;

    // line store port
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    // update terms
    logic [WW-1:0] fill_inc;
    logic [WW-1:0] col_inc;
    logic [SW-1:0] rep_inc;
    logic [SW-1:0] row_inc;
    logic [2:0]    pad_inc;
    logic          row_done;
    logic          block_done;

    // clamp the live register values to their meant ranges
    always_comb
    begin
        if (scale_reg == '0)
            scale_eff = SW'(1);
        else if (scale_reg > pru_pkg::SCALE_MAX)
            scale_eff = pru_pkg::SCALE_MAX;
        else
            scale_eff = scale_reg;

        if (width_reg == '0)
            width_eff = WW'(1);
        else if (32'(width_reg) > 32'(MAX_LINE_WIDTH))
            width_eff = WW'(MAX_LINE_WIDTH);
        else
            width_eff = width_reg;

        // only the low two bits of 3*w*s matter for the padding
        low_bytes = 2'(4'(2'd3 * width_eff[1:0]) * scale_eff[1:0]);
        pad_eff   = 2'(3'd4 - {1'b0, low_bytes});
    end

    // handshakes: ready follows the pipeline, not the fill/drain state
    assign s1_adv       = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = !s1_valid_reg || s1_adv;
    assign accept       = pix_in.valid && pix_in.ready;
    assign cfg.ready    = 1'b1;

    // line store: pixels write while filling, ticks read while draining; one
    // item per cycle so a write and a read never share a cycle, and a read in
    // the cycle after a write already sees the written value
    assign ram_we    = accept && (pix_in.kind == pru_pkg::KIND_PIXEL) && !drain_reg;
    assign ram_waddr = AW'(fill_reg);
    assign ram_raddr = AW'(col_reg);

    pru_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({pix_in.red_in, pix_in.green_in, pix_in.blue_in}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state for one accepted item
    always_comb
    begin
        fill_next    = fill_reg;
        drain_next   = drain_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        rep_next     = rep_reg;
        pad_next     = pad_reg;
        has_result   = 1'b0;
        ram_re       = 1'b0;
        row_done     = 1'b0;
        block_done   = 1'b0;
        s1_meta_next = '{item_kind: pru_pkg::ITEM_REFUSE, row_end: 1'b0, block_end: 1'b0};

        fill_inc = fill_reg + WW'(1);
        col_inc  = col_reg + WW'(1);
        rep_inc  = rep_reg + SW'(1);
        row_inc  = row_reg + SW'(1);
        pad_inc  = {1'b0, pad_reg} + 3'd1;

        if (accept)
        begin
            if (pix_in.kind == pru_pkg::KIND_PIXEL)
            begin
                if (drain_reg)
                begin
                    // pixel while draining: refused
                    has_result = 1'b1;
                end
                else if (fill_inc >= width_eff)
                begin
                    // line complete, start the drain
                    drain_next = 1'b1;
                    fill_next  = '0;
                    row_next   = '0;
                    col_next   = '0;
                    rep_next   = '0;
                    pad_next   = '0;
                end
                else
                begin
                    fill_next = fill_inc;
                end
            end
            else if (drain_reg)
            begin
                has_result = 1'b1;
                if (col_reg < width_eff)
                begin
                    // replicated pixel, data comes from the store next cycle
                    ram_re = 1'b1;
                    s1_meta_next.item_kind = pru_pkg::ITEM_PIXEL;
                    if (rep_inc >= scale_eff)
                    begin
                        rep_next = '0;
                        col_next = col_inc;
                        row_done = (col_inc >= width_eff) && (pad_eff == 2'd0);
                    end
                    else
                    begin
                        rep_next = rep_inc;
                        row_done = (col_reg >= width_eff) && (pad_eff == 2'd0);
                    end
                end
                else
                begin
                    // padding byte; an empty padding phase still ends the row
                    s1_meta_next.item_kind = pru_pkg::ITEM_PAD;
                    pad_next = pad_inc[1:0];
                    row_done = (pad_inc >= {1'b0, pad_eff});
                end

                if (row_done)
                begin
                    row_next   = row_inc;
                    block_done = (row_inc >= scale_eff);
                    col_next   = '0;
                    rep_next   = '0;
                    pad_next   = '0;
                end
                if (block_done)
                begin
                    row_next   = '0;
                    drain_next = 1'b0;
                    fill_next  = '0;
                end
                s1_meta_next.row_end   = row_done;
                s1_meta_next.block_end = block_done;
            end
        end

        s1_valid_next = accept && has_result;
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= SW'(1);
            width_reg     <= WW'(1);
            fill_reg      <= '0;
            drain_reg     <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            rep_reg       <= '0;
            pad_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    pru_pkg::REG_SCALE: scale_reg <= cfg.data[SW-1:0];
                    pru_pkg::REG_WIDTH: width_reg <= cfg.data;
                    default:            scale_reg <= scale_reg;
                endcase
            end
            fill_reg  <= fill_next;
            drain_reg <= drain_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            rep_reg   <= rep_next;
            pad_reg   <= pad_next;
            if (pix_in.ready)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pix_in.ready)
        begin
            s1_meta_reg <= s1_meta_next;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_meta_reg <= s1_meta_reg;
            if (s1_meta_reg.item_kind == pru_pkg::ITEM_PIXEL)
                out_rgb_reg <= ram_rdata;
            else
                out_rgb_reg <= '0;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.item_kind = out_meta_reg.item_kind;
    assign pix_out.red_out   = out_rgb_reg[RW-1 -: CW];
    assign pix_out.green_out = out_rgb_reg[CW +: CW];
    assign pix_out.blue_out  = out_rgb_reg[CW-1:0];
    assign pix_out.row_end   = out_meta_reg.row_end;
    assign pix_out.block_end = out_meta_reg.block_end;

endmodule
